// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define RFN_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("reflect_about_normal_unit: assertion failed");
// Signal pair that must never be high together outside reset.
`define RFN_ASSERT_EXCL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) \
        else $error("reflect_about_normal_unit: exclusive signals both high");
`else
`define RFN_ASSERT(label, clk, rst_n, prop)
`define RFN_ASSERT_EXCL(label, clk, rst_n, a, b)
`endif
`endif

// ----- sv/rfn_pkg.sv -----
`timescale 1ns / 1ps
package rfn_pkg;

    localparam int unsigned CompW = 32;
    localparam int unsigned QBits = 34;   // quotient bits, |q| < 2^34
    localparam int unsigned SumW  = 64;

    typedef logic [2:0][CompW-1:0] t_vec;

    typedef struct packed {
        logic [SumW-1:0]  rem;
        logic [QBits-1:0] lo;
        logic [QBits-1:0] q;
    } t_lane;

    typedef t_lane [2:0] t_lanes;

    typedef struct packed {
        t_vec            v;
        logic [2:0]      flip;
        logic            zero;
        logic [SumW-1:0] s;
    } t_side;

endpackage

// ----- sv/reflect_about_normal_unit.sv -----
`timescale 1ns / 1ps
// Channel  | Direction | tdata (low bit up)                  | tuser
// s_axis   | in        | incident_x,y,z, normal_x,y,z (192b) | none
// m_axis   | out       | reflected_x,y,z (96b)               | zero_normal, saturated
//
// One transaction enters per cycle while the skid register is free; a result
// passes two product/sum stages, three scaling stages, 34 divider steps, one
// rounding stage and one output register on its way out.
// Reset (i_rst_n low at a clock edge) clears all valid bits; data holds none.
// A stall on the output fills a one-entry skid register, after which the
// whole pipeline holds together; nothing is dropped or repeated.
`include "assert_macros.svh"
module reflect_about_normal_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // incident_x[31:0], incident_y[63:32], incident_z[95:64],
    // normal_x[127:96], normal_y[159:128], normal_z[191:160]
    input  logic [191:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // reflected_x[31:0], reflected_y[63:32], reflected_z[95:64]
    output logic [95:0]  o_m_tdata,
    // zero_normal[0], saturated[1]
    output logic [1:0]   o_m_tuser
);
    import rfn_pkg::*;

    // The pipeline moves whenever the skid register is free.
    logic   w_en;
    t_vec   w_v, w_n;
    logic   w_dot_valid;
    logic [63:0] w_pos, w_neg, w_s;
    t_vec   w_dv, w_nmag;
    logic [2:0] w_nneg;

    logic   w_div_valid [QBits+1];
    t_lanes w_lanes [QBits+1];
    t_side  w_side [QBits+1];

    logic   w_fin_valid, w_fin_zero, w_fin_sat;
    t_vec   w_fin_r;

    logic        r_skid_v;
    logic [97:0] r_skid;
    logic [97:0] w_fin_word;

    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i] = i_s_tdata[32*i +: 32];
            w_n[i] = i_s_tdata[96 + 32*i +: 32];
        end
    end

    rfn_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_v     (w_v),
        .i_n     (w_n),
        .o_valid (w_dot_valid),
        .o_pos   (w_pos),
        .o_neg   (w_neg),
        .o_s     (w_s),
        .o_v     (w_dv),
        .o_nneg  (w_nneg),
        .o_nmag  (w_nmag)
    );

    rfn_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dot_valid),
        .i_pos   (w_pos),
        .i_neg   (w_neg),
        .i_s     (w_s),
        .i_v     (w_dv),
        .i_nneg  (w_nneg),
        .i_nmag  (w_nmag),
        .o_valid (w_div_valid[0]),
        .o_lanes (w_lanes[0]),
        .o_side  (w_side[0])
    );

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < QBits; k++) begin : g_div
        rfn_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_div_valid[k]),
            .i_lanes (w_lanes[k]),
            .i_side  (w_side[k]),
            .o_valid (w_div_valid[k+1]),
            .o_lanes (w_lanes[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    rfn_fin u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_valid[QBits]),
        .i_lanes (w_lanes[QBits]),
        .i_side  (w_side[QBits]),
        .o_valid (w_fin_valid),
        .o_r     (w_fin_r),
        .o_zero  (w_fin_zero),
        .o_sat   (w_fin_sat)
    );

    assign w_fin_word = {w_fin_sat, w_fin_zero, w_fin_r};

    // Output register with a one-entry skid behind it. A result leaving the
    // pipeline goes straight to the output when that is free or draining,
    // otherwise it parks in the skid register and the pipeline holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
            r_skid_v   <= 1'b0;
        end else if (!o_m_tvalid || i_m_tready) begin
            o_m_tvalid <= r_skid_v || w_fin_valid;
            r_skid_v   <= 1'b0;
        end else if (w_en && w_fin_valid) begin
            r_skid_v <= 1'b1;
        end
        if (!o_m_tvalid || i_m_tready) begin
            {o_m_tuser, o_m_tdata} <= r_skid_v ? r_skid : w_fin_word;
        end else if (w_en && w_fin_valid) begin
            r_skid <= w_fin_word;
        end
    end

    `RFN_ASSERT(a_skid_needs_out, i_clk, i_rst_n, r_skid_v |-> o_m_tvalid)
    `RFN_ASSERT_EXCL(a_skid_blocks_in, i_clk, i_rst_n, r_skid_v, o_s_tready)
    `RFN_ASSERT(a_zero_clean, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser[0]) |-> (!o_m_tuser[1] && o_m_tdata == 96'd0))

endmodule

// ----- sv/rfn_dot.sv -----
`timescale 1ns / 1ps
module rfn_dot (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  rfn_pkg::t_vec          i_v,
    input  rfn_pkg::t_vec          i_n,
    output logic                   o_valid,
    output logic [63:0]            o_pos,
    output logic [63:0]            o_neg,
    output logic [63:0]            o_s,
    output rfn_pkg::t_vec          o_v,
    output logic [2:0]             o_nneg,
    output rfn_pkg::t_vec          o_nmag
);
    import rfn_pkg::*;

    logic              r1_valid;
    logic [2:0][63:0]  r1_p, r1_nn;
    logic [2:0]        r1_pneg, r1_nneg;
    t_vec              r1_v, r1_nmag;
    t_vec              n_vmag, n_nmag;
    logic [63:0]       n_pos, n_neg, n_s;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_vmag[i] = i_v[i][31] ? (~i_v[i] + 32'd1) : i_v[i];
            n_nmag[i] = i_n[i][31] ? (~i_n[i] + 32'd1) : i_n[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_p[i]    <= 64'(n_vmag[i]) * 64'(n_nmag[i]);
                r1_nn[i]   <= 64'(n_nmag[i]) * 64'(n_nmag[i]);
                r1_pneg[i] <= i_v[i][31] ^ i_n[i][31];
                r1_nneg[i] <= i_n[i][31];
            end
            r1_v    <= i_v;
            r1_nmag <= n_nmag;
        end
    end

    always_comb begin
        n_pos = 64'd0;
        n_neg = 64'd0;
        n_s   = 64'd0;
        for (int i = 0; i < 3; i++) begin
            if (r1_pneg[i]) begin
                n_neg = n_neg + r1_p[i];
            end else begin
                n_pos = n_pos + r1_p[i];
            end
            n_s = n_s + r1_nn[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r1_valid;
        end
        if (i_en) begin
            o_pos  <= n_pos;
            o_neg  <= n_neg;
            o_s    <= n_s;
            o_v    <= r1_v;
            o_nneg <= r1_nneg;
            o_nmag <= r1_nmag;
        end
    end

endmodule

// ----- sv/rfn_scale.sv -----
`timescale 1ns / 1ps
module rfn_scale (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_pos,
    input  logic [63:0]     i_neg,
    input  logic [63:0]     i_s,
    input  rfn_pkg::t_vec   i_v,
    input  logic [2:0]      i_nneg,
    input  rfn_pkg::t_vec   i_nmag,
    output logic            o_valid,
    output rfn_pkg::t_lanes o_lanes,
    output rfn_pkg::t_side  o_side
);
    import rfn_pkg::*;

    logic              r3_valid, r4_valid;
    logic [63:0]       r3_dmag;
    logic [2:0][32:0]  r3_m;
    t_side             r3_side, r4_side;
    logic [2:0][64:0]  r4_lo, r4_hi;
    logic              n_dneg;
    logic [2:0][96:0]  n_num;

    assign n_dneg = i_neg > i_pos;

    // Stage three: magnitude and sign of the dot product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
            o_valid  <= r4_valid;
        end
        if (i_en) begin
            r3_dmag      <= n_dneg ? (i_neg - i_pos) : (i_pos - i_neg);
            r3_side.v    <= i_v;
            r3_side.flip <= i_nneg ^ {3{n_dneg}};
            r3_side.zero <= i_s == 64'd0;
            r3_side.s    <= i_s;
            for (int i = 0; i < 3; i++) begin
                r3_m[i] <= {i_nmag[i], 1'b0};
            end
        end
    end

    // Stage four: the 64 by 33 product as two 32 by 33 halves.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_lo[i] <= 65'(r3_dmag[31:0]) * 65'(r3_m[i]);
                r4_hi[i] <= 65'(r3_dmag[63:32]) * 65'(r3_m[i]);
            end
            r4_side <= r3_side;
        end
    end

    // Stage five: join the halves; the top bits seed the divider remainder.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = 97'(r4_lo[i]) + {r4_hi[i][64:0], 32'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                o_lanes[i].rem <= {1'b0, n_num[i][96:QBits]};
                o_lanes[i].lo  <= n_num[i][QBits-1:0];
                o_lanes[i].q   <= '0;
            end
            o_side <= r4_side;
        end
    end

endmodule

// ----- sv/rfn_div_step.sv -----
`timescale 1ns / 1ps
module rfn_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  rfn_pkg::t_lanes i_lanes,
    input  rfn_pkg::t_side  i_side,
    output logic            o_valid,
    output rfn_pkg::t_lanes o_lanes,
    output rfn_pkg::t_side  o_side
);
    import rfn_pkg::*;

    logic [2:0][64:0] n_t, n_d;
    logic [2:0]       n_ge;

    // One restoring step per lane; the remainder always stays below S.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i]  = {i_lanes[i].rem, i_lanes[i].lo[QBits-1]};
            n_ge[i] = n_t[i] >= {1'b0, i_side.s};
            n_d[i]  = n_t[i] - {1'b0, i_side.s};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                o_lanes[i].rem <= n_ge[i] ? n_d[i][63:0] : n_t[i][63:0];
                o_lanes[i].lo  <= {i_lanes[i].lo[QBits-2:0], 1'b0};
                o_lanes[i].q   <= {i_lanes[i].q[QBits-2:0], n_ge[i]};
            end
            o_side <= i_side;
        end
    end

endmodule

// ----- sv/rfn_fin.sv -----
`timescale 1ns / 1ps
module rfn_fin (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  rfn_pkg::t_lanes i_lanes,
    input  rfn_pkg::t_side  i_side,
    output logic            o_valid,
    output rfn_pkg::t_vec   o_r,
    output logic            o_zero,
    output logic            o_sat
);
    import rfn_pkg::*;

    logic [2:0][QBits:0]        n_qm;
    logic signed [2:0][QBits+1:0] n_qs;
    logic signed [2:0][QBits+2:0] n_diff;
    logic [2:0]                 n_hi, n_low;
    t_vec                       n_r;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // Round half away from zero on the magnitude.
            n_qm[i] = {1'b0, i_lanes[i].q} +
                      (QBits+1)'({i_lanes[i].rem, 1'b0} >= {1'b0, i_side.s});
            n_qs[i] = i_side.flip[i] ? -$signed({1'b0, n_qm[i]})
                                     : $signed({1'b0, n_qm[i]});
            // Element selects are unsigned, so the sign is restored explicitly.
            n_diff[i] = (QBits+3)'($signed(n_qs[i])) -
                        (QBits+3)'($signed(i_side.v[i]));
            n_hi[i]  = $signed(n_diff[i]) > $signed((QBits+3)'(32'h7FFF_FFFF));
            n_low[i] = $signed(n_diff[i]) < -$signed((QBits+3)'(32'h8000_0000));
            if (n_hi[i]) begin
                n_r[i] = 32'h7FFF_FFFF;
            end else if (n_low[i]) begin
                n_r[i] = 32'h8000_0000;
            end else begin
                n_r[i] = n_diff[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_r    <= i_side.zero ? '0 : n_r;
            o_zero <= i_side.zero;
            o_sat  <= !i_side.zero && |(n_hi | n_low);
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Reflection of an incident vector about a normal: R = 2(V.N)N/(N.N) - V,
// rounded half away from zero and saturated to 32 bits.
class reflection_scoreboard;
    logic [97:0] pending_q[$];
    int unsigned fail_count;
    int unsigned checked_count;
    int unsigned zero_count;
    int unsigned sat_count;

    function new();
        fail_count = 0;
        checked_count = 0;
        zero_count = 0;
        sat_count = 0;
    endfunction

    // Works out the reflected vector and flags for one input transaction.
    function logic [97:0] reflect(logic [191:0] data);
        logic signed [31:0] inc[3];
        logic signed [31:0] nrm[3];
        logic signed [67:0] dot;
        logic signed [67:0] len_sq;
        logic signed [135:0] num;
        logic signed [135:0] den;
        logic signed [135:0] quo;
        logic signed [135:0] rem;
        logic signed [135:0] res;
        logic [95:0] vec;
        logic sat;
        vec = '0;
        sat = 1'b0;
        dot = '0;
        len_sq = '0;
        for (int i = 0; i < 3; i++) begin
            inc[i] = data[32*i +: 32];
            nrm[i] = data[96 + 32*i +: 32];
        end
        for (int i = 0; i < 3; i++) begin
            dot += 68'(inc[i]) * 68'(nrm[i]);
            len_sq += 68'(nrm[i]) * 68'(nrm[i]);
        end
        if (len_sq == 0) begin
            return {1'b0, 1'b1, 96'd0};
        end
        den = 136'(len_sq);
        for (int i = 0; i < 3; i++) begin
            num = 136'(dot) * 136'(nrm[i]) * 2;
            if (num < 0) begin
                num = -num;
            end
            quo = num / den;
            rem = num - quo * den;
            if (2 * rem >= den) begin
                quo += 1;
            end
            // The sign of the quotient follows dot product times normal.
            if ((dot < 0) != (nrm[i] < 0)) begin
                quo = -quo;
            end
            res = quo - 136'(inc[i]);
            if (res > 136'sh7FFFFFFF) begin
                res = 136'sh7FFFFFFF;
                sat = 1'b1;
            end else if (res < -136'sh80000000) begin
                res = -136'sh80000000;
                sat = 1'b1;
            end
            vec[32*i +: 32] = res[31:0];
        end
        return {sat, 1'b0, vec};
    endfunction

    function void note_input(logic [191:0] data);
        pending_q.push_back(reflect(data));
    endfunction

    function void check_result(logic [95:0] data, logic [1:0] user);
        logic [97:0] want;
        if (pending_q.size() == 0) begin
            $error("result with no expectation: tdata %h tuser %b", data, user);
            fail_count++;
            return;
        end
        want = pending_q.pop_front();
        checked_count++;
        if (want[96]) zero_count++;
        if (want[97]) sat_count++;
        for (int i = 0; i < 3; i++) begin
            if (data[32*i +: 32] !== want[32*i +: 32]) begin
                $error("reflected_%0d: expected %h, actual %h", i,
                    want[32*i +: 32], data[32*i +: 32]);
                fail_count++;
            end
        end
        if (user[0] !== want[96]) begin
            $error("zero_normal: expected %b, actual %b", want[96], user[0]);
            fail_count++;
        end
        if (user[1] !== want[97]) begin
            $error("saturated: expected %b, actual %b", want[97], user[1]);
            fail_count++;
        end
    endfunction
endclass

module testbench;
    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // incident_x,y,z then normal_x,y,z, 32 bits each from the lowest bit up.
    logic [191:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // reflected_x,y,z, 32 bits each from the lowest bit up.
    logic [95:0]  o_m_tdata;
    // zero_normal, saturated.
    logic [1:0]   o_m_tuser;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned DrainCycles = 60;

    reflection_scoreboard board;
    logic [191:0] directed_q[$];
    int unsigned cycle_count;
    logic calm;

    reflect_about_normal_unit u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle counter guarding against a hung pipeline.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Results are sampled at the edge where the transaction completes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_result(o_m_tdata, o_m_tuser);
        end
    end

    // The receiver stalls at random about 7 percent of the time, except in the calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(99) >= 7);
        end
    end

    function automatic logic [31:0] pick_component();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'($signed($urandom_range(131072)) - 65536);
            4: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [191:0] random_item();
        logic [191:0] item;
        for (int i = 0; i < 6; i++) begin
            item[32*i +: 32] = pick_component();
        end
        // A share of items carry a zero normal.
        if ($urandom_range(19) == 0) begin
            item[191:96] = '0;
        end
        return item;
    endfunction

    // After random idle gaps outside the calm stretch, presents one transaction and holds it until it is taken.
    task automatic send_item(logic [191:0] item);
        while (!calm && $urandom_range(99) < 7) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= item;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        board.note_input(item);
    endtask

    initial begin
        int unsigned wait_count;
        board = new();
        cycle_count = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases: zero normal, axis normals, extremes, saturation, rounding.
        directed_q.push_back({96'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000});
        directed_q.push_back({96'd0, {3{32'h8000_0000}}});
        directed_q.push_back({32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000});
        directed_q.push_back({32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'd0});
        directed_q.push_back({{3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}}});
        directed_q.push_back({{3{32'h8000_0000}}, {3{32'h8000_0000}}});
        directed_q.push_back({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}});
        directed_q.push_back({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}});
        directed_q.push_back({32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'h8000_0000});
        directed_q.push_back({32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0, 32'h7FFF_FFFF});
        directed_q.push_back({32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1});
        directed_q.push_back({32'd3, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0});
        directed_q.push_back({32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0});
        directed_q.push_back({32'd1, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        directed_q.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000});
        foreach (directed_q[i]) begin
            send_item(directed_q[i]);
        end

        for (int n = 0; n < 1800; n++) begin
            calm = (n >= 700 && n < 1000);
            send_item(random_item());
        end
        i_s_tvalid <= 1'b0;
        calm = 1'b0;

        wait_count = 0;
        while (board.pending_q.size() != 0 && wait_count < 20000) begin
            @(posedge i_clk);
            wait_count++;
        end
        repeat (DrainCycles) @(posedge i_clk);

        $display("Checked %0d reflections, %0d with a zero normal, %0d saturated.",
            board.checked_count, board.zero_count, board.sat_count);
        if (board.fail_count == 0 && board.pending_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
